>>> rtl/rc4_pkg.sv
// RC4 cipher package: sizes, item codes, sequencer states and the
// permutation memory request struct. Used by every file under rtl/.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int PERM_SIZE = 256;
  localparam int PERM_AW   = $clog2(PERM_SIZE);
  localparam logic [PERM_AW-1:0] PERM_MAX = PERM_AW'(PERM_SIZE - 1);

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);
  localparam logic [KEY_CW-1:0] KEY_FULL = KEY_CW'(KEY_DEPTH);

  // item codes on in_operation
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_RD,      // schedule: read S[n] and K[n % len]
    ST_S_J,       // schedule: j update, read S[j]
    ST_S_WR_N,    // schedule: S[n] <= S[j]
    ST_S_WR_J,    // schedule: S[j] <= old S[n]
    ST_D_J,       // data: j update, read S[j]
    ST_D_WR_I,    // data: S[i] <= S[j]
    ST_D_WR_J,    // data: S[j] <= old S[i]
    ST_D_RD_T,    // data: read S[S[i]+S[j]]
    ST_D_OUT      // data: load result register
  } state_t;

  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [PERM_AW-1:0] rd_addr;
    logic               wr_en;
    logic [PERM_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } perm_req_t;

endpackage

>>> rtl/rc4_perm_ram.sv
// RC4 permutation memory: 256 x 8, one read and one write port, registered read.
// Per-entry valid bits make an unwritten entry read as its own index. Uses rc4_pkg.
`timescale 1ns / 1ps

module rc4_perm_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  rc4_pkg::perm_req_t  req,
  output logic [7:0]          rd_data
);

  logic [7:0]                  mem [rc4_pkg::PERM_SIZE];
  logic [rc4_pkg::PERM_SIZE-1:0] valid_r;
  logic [7:0]                  mem_q_r;
  logic [rc4_pkg::PERM_AW-1:0] raddr_r;
  logic                        hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.rd_addr];
      raddr_r <= req.rd_addr;
      hit_r   <= valid_r[req.rd_addr];
    end
  end

  // clear puts the whole table back to identity by dropping every valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = hit_r ? mem_q_r : 8'(raddr_r);

endmodule

>>> rtl/rc4_stream_cipher_unit.sv
// RC4 stream cipher top level: key store, sequencer and result register.
// Instantiates rc4_perm_ram; uses rc4_pkg.
`timescale 1ns / 1ps

// RC4 byte cipher. Send key bytes with in_operation = 0; the one with
// in_key_last = 1 resets the permutation to identity, runs the 256-round key
// schedule and clears the generator indices i and j. Bytes past the 256th key
// byte are dropped. Send data bytes with in_operation = 1; each returns one
// out_cipher_byte = data ^ keystream (the same call encrypts and decrypts).
// Key items give no result. Sequence: a key byte other than the last leaves the
// block idle and ready; the last key byte adds the schedule, round by round on the
// single permutation memory: read S[n], read S[j], write S[n], write S[j]. A data
// byte takes the same memory in order: read S[i], read S[j], write S[i], write S[j],
// read S[t], then the result load; the next item is taken only after that load.
// in_ready is low while an item is in work.
// A finished result sits in the output register and a new item is accepted
// meanwhile; the block waits only if the next result is ready before the old
// one was taken. Data sent before any key runs on the identity permutation.

module rc4_stream_cipher_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_byte_value,
  input  logic       in_key_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_cipher_byte
);

  localparam int PAW = rc4_pkg::PERM_AW;
  localparam int KAW = rc4_pkg::KEY_AW;
  localparam int KCW = rc4_pkg::KEY_CW;

  rc4_pkg::state_t    state_r, state_nxt;
  logic [KCW-1:0]     key_count_r, key_count_nxt;
  logic [PAW-1:0]     index_i_r, index_i_nxt;
  logic [PAW-1:0]     index_j_r, index_j_nxt;
  logic [PAW-1:0]     n_r, n_nxt;         // schedule round
  logic [KAW-1:0]     kidx_r, kidx_nxt;   // n % key length
  logic [KCW-1:0]     klen_r, klen_nxt;
  logic [7:0]         sa_r, sa_nxt;       // S[n] or S[i] held for the swap
  logic [7:0]         sb_r, sb_nxt;       // S[j] held for the sum
  logic [7:0]         byte_r, byte_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;

  logic [7:0]         key_mem [rc4_pkg::KEY_DEPTH];
  logic [7:0]         key_q_r;
  logic               key_wr_en;

  rc4_pkg::perm_req_t perm_req;
  logic [7:0]         perm_rd;

  logic               in_acc;
  logic [KCW-1:0]     count_after;
  logic [PAW-1:0]     j_sched;
  logic [PAW-1:0]     j_data;
  logic [PAW-1:0]     i_inc;

  rc4_perm_ram u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (perm_req),
    .rd_data (perm_rd)
  );

  assign in_ready        = (state_r == rc4_pkg::ST_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

  // saturating key count including the byte being accepted
  assign count_after = (key_count_r < rc4_pkg::KEY_FULL) ?
                       KCW'(key_count_r + 1'b1) : key_count_r;
  assign key_wr_en   = in_acc && (in_operation == rc4_pkg::OP_KEY) &&
                       (key_count_r < rc4_pkg::KEY_FULL);

  assign j_sched = PAW'(index_j_r + perm_rd + key_q_r);
  assign j_data  = PAW'(index_j_r + perm_rd);
  assign i_inc   = PAW'(index_i_r + 1'b1);

  // key store
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_count_r[KAW-1:0]] <= in_byte_value;
    end
    if (state_r == rc4_pkg::ST_S_RD) begin
      key_q_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      key_count_r <= '0;
      index_i_r   <= '0;
      index_j_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      index_i_r   <= index_i_nxt;
      index_j_r   <= index_j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    kidx_r     <= kidx_nxt;
    klen_r     <= klen_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    byte_r     <= byte_nxt;
    out_byte_r <= out_byte_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    index_i_nxt   = index_i_r;
    index_j_nxt   = index_j_r;
    n_nxt         = n_r;
    kidx_nxt      = kidx_r;
    klen_nxt      = klen_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    byte_nxt      = byte_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_ready;
    perm_req      = '0;

    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == rc4_pkg::OP_KEY) begin
            if (in_key_last) begin
              // start schedule from identity with j = 0
              perm_req.clear = 1'b1;
              key_count_nxt  = '0;
              klen_nxt       = count_after;
              n_nxt          = '0;
              kidx_nxt       = '0;
              index_j_nxt    = '0;
              state_nxt      = rc4_pkg::ST_S_RD;
            end else begin
              key_count_nxt = count_after;
            end
          end else begin
            byte_nxt         = in_byte_value;
            index_i_nxt      = i_inc;
            perm_req.rd_en   = 1'b1;
            perm_req.rd_addr = i_inc;
            state_nxt        = rc4_pkg::ST_D_J;
          end
        end
      end

      // key schedule, one round per pass through ST_S_RD to ST_S_WR_J
      rc4_pkg::ST_S_RD: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = n_r;
        state_nxt        = rc4_pkg::ST_S_J;
      end
      rc4_pkg::ST_S_J: begin
        sa_nxt           = perm_rd;
        index_j_nxt      = j_sched;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = j_sched;
        state_nxt        = rc4_pkg::ST_S_WR_N;
      end
      rc4_pkg::ST_S_WR_N: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = n_r;
        perm_req.wr_data = perm_rd;
        state_nxt        = rc4_pkg::ST_S_WR_J;
      end
      rc4_pkg::ST_S_WR_J: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = index_j_r;
        perm_req.wr_data = sa_r;
        n_nxt            = PAW'(n_r + 1'b1);
        // key index wraps at the key length
        if (KCW'(kidx_r + 1'b1) == klen_r) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = KAW'(kidx_r + 1'b1);
        end
        if (n_r == rc4_pkg::PERM_MAX) begin
          index_i_nxt = '0;
          index_j_nxt = '0;
          state_nxt   = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_S_RD;
        end
      end

      // keystream step
      rc4_pkg::ST_D_J: begin
        sa_nxt           = perm_rd;
        index_j_nxt      = j_data;
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = j_data;
        state_nxt        = rc4_pkg::ST_D_WR_I;
      end
      rc4_pkg::ST_D_WR_I: begin
        sb_nxt           = perm_rd;
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = index_i_r;
        perm_req.wr_data = perm_rd;
        state_nxt        = rc4_pkg::ST_D_WR_J;
      end
      rc4_pkg::ST_D_WR_J: begin
        perm_req.wr_en   = 1'b1;
        perm_req.wr_addr = index_j_r;
        perm_req.wr_data = sa_r;
        state_nxt        = rc4_pkg::ST_D_RD_T;
      end
      rc4_pkg::ST_D_RD_T: begin
        perm_req.rd_en   = 1'b1;
        perm_req.rd_addr = PAW'(sa_r + sb_r);
        state_nxt        = rc4_pkg::ST_D_OUT;
      end
      rc4_pkg::ST_D_OUT: begin
        // wait here only while the previous result is still held
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = byte_r ^ perm_rd;
          state_nxt     = rc4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // ---- assertions ----
  a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= rc4_pkg::KEY_FULL)
    else $error("key count beyond key depth");

  a_perm_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(perm_req.rd_en && perm_req.wr_en))
    else $error("permutation read and write in one cycle");

  a_last_key_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_operation == rc4_pkg::OP_KEY) && in_key_last) |=>
      ((state_r == rc4_pkg::ST_S_RD) && (key_count_r == '0) && (index_j_r == '0)))
    else $error("last key byte did not start the schedule");

  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rc4_pkg::ST_S_WR_J) && (n_r == rc4_pkg::PERM_MAX)) |=>
      ((state_r == rc4_pkg::ST_IDLE) && (index_i_r == '0) && (index_j_r == '0)))
    else $error("schedule end did not clear indices");

endmodule

>>> verif/rc4_stream_cipher_unit_tb.sv
// Self-checking testbench for rc4_stream_cipher_unit: key loads, key scheduling
// and keystream XOR checked against an in-bench RC4 predictor.
// Depends on rtl/rc4_pkg.sv, rtl/rc4_stream_cipher_unit.sv and rtl/rc4_perm_ram.sv.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit_tb;

  // Quiet-cycle limit: a key schedule plus long random stalls on both sides,
  // taken many times over.
  localparam int QUIET_LIMIT  = 20000;
  // After the last result: enough for a trailing key schedule to finish.
  localparam int DRAIN_CYCLES = 1100;
  localparam int ITEMS_PER_MODE = 340;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_operation = rc4_pkg::OP_KEY;
  logic [7:0] in_byte_value = 8'h00;
  logic       in_key_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_cipher_byte;

  // idle rates in percent, changed per phase of the run
  int in_idle_pct  = 31;
  int out_idle_pct = 82;

  // predictor state: permutation, key bytes of the current load, PRGA indices
  logic [7:0] perm_model [rc4_pkg::PERM_SIZE];
  logic [7:0] key_model [rc4_pkg::KEY_DEPTH];
  int         key_len_model;
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] expected_cipher_q [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int keys_scheduled  = 0;
  int data_items      = 0;
  int quiet_cycles    = 0;
  logic [7:0] want_byte;

  rc4_stream_cipher_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_byte_value   (in_byte_value),
    .in_key_last     (in_key_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cipher_byte (out_cipher_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // RC4 predictor
  // ---------------------------------------------------------------------------

  // KSA: identity, then 256 swap rounds driven by the stored key bytes
  function automatic void schedule_perm(input int key_len);
    logic [7:0] j;
    logic [7:0] held;
    j = 8'h00;
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) perm_model[n] = 8'(n);
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
      j = j + perm_model[n] + key_model[n % key_len];
      held = perm_model[n];
      perm_model[n] = perm_model[j];
      perm_model[j] = held;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
  endfunction

  // Apply one accepted item; data items queue the expected cipher byte.
  function automatic void predict_cipher(input logic op, input logic [7:0] value,
                                         input logic last);
    logic [7:0] held;
    logic [7:0] t;
    if (op == rc4_pkg::OP_KEY) begin
      // key bytes past the store depth are dropped, count saturates
      if (key_len_model < rc4_pkg::KEY_DEPTH) begin
        key_model[key_len_model] = value;
        key_len_model++;
      end
      if (last) begin
        schedule_perm(key_len_model);
        key_len_model = 0;
        keys_scheduled++;
      end
    end else begin
      // key_last is don't-care on data items
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm_model[idx_i];
      held = perm_model[idx_i];
      perm_model[idx_i] = perm_model[idx_j];
      perm_model[idx_j] = held;
      t = perm_model[idx_i] + perm_model[idx_j];
      expected_cipher_q.insert(expected_cipher_q.size(), value ^ perm_model[t]);
      data_items++;
    end
  endfunction

  initial begin
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) perm_model[n] = 8'(n);
    for (int n = 0; n < rc4_pkg::KEY_DEPTH; n++) key_model[n] = 8'h00;
    key_len_model = 0;
    idx_i = 8'h00;
    idx_j = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // Driver: one item per call. Valid is held across back-to-back items; each
  // time step gets at most one assignment to in_valid.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [7:0] value, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_byte_value <= value;
    in_key_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cipher(op, value, last);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order compare
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR t=%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_cipher_q.size() == 0) begin
        report_mismatch($sformatf("unexpected cipher byte 0x%02h", out_cipher_byte));
      end else begin
        want_byte = expected_cipher_q.pop_front();
        if (out_cipher_byte !== want_byte)
          report_mismatch($sformatf("cipher byte 0x%02h, want 0x%02h (result %0d)",
                                    out_cipher_byte, want_byte, results_checked));
      end
    end
  end

  // watchdog: counts cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_cipher_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // generator on the reset permutation, byte extremes
  task automatic test_data_before_key();
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h01, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h80, 1'b0);
  endtask

  // key_last set on data must not start a schedule
  task automatic test_key_last_on_data();
    send_item(rc4_pkg::OP_DATA, 8'h5A, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'hA5, 1'b1);
  endtask

  // shortest keys at both byte extremes; each schedule restarts the key count
  task automatic test_single_byte_keys();
    send_item(rc4_pkg::OP_KEY, 8'h00, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_KEY, 8'hFF, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
  endtask

  // data in the middle of a key load runs on the old permutation
  task automatic test_data_during_key_load();
    send_item(rc4_pkg::OP_KEY, 8'h01, 1'b0);
    send_item(rc4_pkg::OP_KEY, 8'h02, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h33, 1'b0);
    send_item(rc4_pkg::OP_KEY, 8'h04, 1'b0);
    send_item(rc4_pkg::OP_KEY, 8'h05, 1'b1);
    send_item(rc4_pkg::OP_DATA, 8'h11, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h22, 1'b0);
    send_item(rc4_pkg::OP_DATA, 8'h44, 1'b0);
  endtask

  // full-depth key, then an over-long one whose tail and last byte are dropped
  task automatic test_long_keys();
    int extra;
    for (int k = 0; k < rc4_pkg::KEY_DEPTH; k++)
      send_item(rc4_pkg::OP_KEY, 8'($urandom_range(255)), k == rc4_pkg::KEY_DEPTH - 1);
    for (int d = 0; d < 8; d++)
      send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), 1'b0);
    extra = $urandom_range(1, 20);
    for (int k = 0; k < rc4_pkg::KEY_DEPTH + extra; k++)
      send_item(rc4_pkg::OP_KEY, 8'($urandom_range(255)),
                k == rc4_pkg::KEY_DEPTH + extra - 1);
    for (int d = 0; d < 8; d++)
      send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), 1'b0);
  endtask

  // mostly well-formed sessions (key load, then a data run) plus noise items
  task automatic test_random_sessions(input int n_items);
    int sent;
    int key_len;
    int data_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        key_len = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 40);
        for (int k = 0; k < key_len; k++) begin
          if (k > 0 && $urandom_range(99) < 8) begin
            send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
          end
          send_item(rc4_pkg::OP_KEY, 8'($urandom_range(255)), k == key_len - 1);
          sent++;
        end
        data_len = $urandom_range(4, 40);
        for (int d = 0; d < data_len; d++) begin
          send_item(rc4_pkg::OP_DATA, 8'($urandom_range(255)), $urandom_range(99) < 10);
          sent++;
        end
      end else begin
        for (int n = $urandom_range(1, 8); n > 0; n--) begin
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(99) < 25);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    in_idle_pct  = 31;
    out_idle_pct = 82;
    test_data_before_key();
    test_key_last_on_data();
    test_single_byte_keys();
    test_data_during_key_load();
    test_long_keys();
    test_random_sessions(ITEMS_PER_MODE);

    // sides swapped
    in_idle_pct  = 82;
    out_idle_pct = 31;
    test_random_sessions(ITEMS_PER_MODE);

    // full throughput
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_sessions(ITEMS_PER_MODE);

    in_valid <= 1'b0;
    while (expected_cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d key schedules (incl. full-depth and over-long keys), %0d data items",
             keys_scheduled, data_items);
    $display("checked %0d cipher bytes under three idle mixes, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
